>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the shelf packer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define GASP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define GASP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/gasp_pkg.sv
// Types and constants of the glyph atlas shelf packer
package gasp_pkg;

   localparam int GLYPH_CODE_BITS = 21;
   localparam int GLYPH_DIM_BITS  = 12;
   localparam int POS_BITS        = 12;
   localparam int PAGE_OUT_BITS   = 8;
   localparam int ATLAS_DIM_BITS  = 13;
   localparam int CSR_DATA_BITS   = 4;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int WIDE_BITS       = 15;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PADDING      = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DIM_LOG2 = 1'd1;

   localparam logic [3:0] PADDING_RESET      = 4'd1;
   localparam logic [3:0] MAX_DIM_LOG2_RESET = 4'd11;
   localparam logic [3:0] MIN_LOG2           = 4'd7;
   localparam logic [3:0] MAX_TOP_LOG2       = 4'd12;

   typedef enum logic [1:0] {
      STATUS_PLACED,
      STATUS_EMPTY,
      STATUS_OVERSIZE,
      STATUS_REGROW
   } status_type;

endpackage

>>> hw/rtl/glyph_atlas_shelf_packer_unit.sv
// Top level of the glyph atlas shelf packer: input stage, packer state, result stage
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | glyph_code, glyph_width, glyph_height
//   rsp_     | out       | rsp_valid/rsp_stall  | code_out, status, pos, page, atlas size
//   csr_     | in        | csr_write            | csr_index, csr_wdata
//
// One beat per cycle sustained while the result port is not stalled. The input register
// takes a beat at its accepting edge; once the result register is free, the beat moves
// through the placement logic into the result register, which drives the result port.
// Packer state updates as each beat moves into the result register.
// Reset clears valid flags and sets packer state and CSRs to their reset values; payload registers are not reset.
// A stalled result holds and stalls the input stage behind it.
module glyph_atlas_shelf_packer_unit #(
   parameter int COORD_BITS = 12,
   parameter int PAGE_BITS  = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [gasp_pkg::GLYPH_CODE_BITS-1:0]  req_glyph_code,
   input  logic [gasp_pkg::GLYPH_DIM_BITS-1:0]   req_glyph_width,
   input  logic [gasp_pkg::GLYPH_DIM_BITS-1:0]   req_glyph_height,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [gasp_pkg::GLYPH_CODE_BITS-1:0]  rsp_code_out,
   output logic [1:0]                            rsp_status,
   output logic [gasp_pkg::POS_BITS-1:0]         rsp_pos_x,
   output logic [gasp_pkg::POS_BITS-1:0]         rsp_pos_y,
   output logic [gasp_pkg::PAGE_OUT_BITS-1:0]    rsp_page_out,
   output logic [gasp_pkg::ATLAS_DIM_BITS-1:0]   rsp_atlas_width,
   output logic [gasp_pkg::ATLAS_DIM_BITS-1:0]   rsp_atlas_height,
   input  logic                                  csr_write,
   input  logic [gasp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gasp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int W = gasp_pkg::WIDE_BITS;

   logic [3:0] padding_ff, max_dim_log2_ff;

   logic                                 req_valid_ff;
   logic [gasp_pkg::GLYPH_CODE_BITS-1:0] req_code_ff;
   logic [gasp_pkg::GLYPH_DIM_BITS-1:0]  req_width_ff, req_height_ff;

   logic [COORD_BITS-1:0] cursor_x_ff, cursor_y_ff, row_height_ff;
   logic [COORD_BITS-1:0] cursor_x_in, cursor_y_in, row_height_in;
   logic [3:0]            width_log2_ff, height_log2_ff, width_log2_in, height_log2_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;

   gasp_pkg::status_type  status_c;
   logic [COORD_BITS-1:0] pos_x_c, pos_y_c;
   logic [W-1:0]          pos_x_wide, pos_y_wide;
   logic [15:0]           page_wide;

   logic                                 rsp_valid_ff;
   logic [gasp_pkg::GLYPH_CODE_BITS-1:0] rsp_code_ff;
   logic [1:0]                           rsp_status_ff;
   logic [gasp_pkg::POS_BITS-1:0]        rsp_pos_x_ff, rsp_pos_y_ff;
   logic [gasp_pkg::PAGE_OUT_BITS-1:0]   rsp_page_ff;
   logic [gasp_pkg::ATLAS_DIM_BITS-1:0]  rsp_atlas_width_ff, rsp_atlas_height_ff;

   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !out_free;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         padding_ff      <= gasp_pkg::PADDING_RESET;
         max_dim_log2_ff <= gasp_pkg::MAX_DIM_LOG2_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gasp_pkg::CSR_PADDING:      padding_ff      <= csr_wdata;
            gasp_pkg::CSR_MAX_DIM_LOG2: max_dim_log2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (!req_stall) begin
         req_code_ff   <= req_glyph_code;
         req_width_ff  <= req_glyph_width;
         req_height_ff <= req_glyph_height;
      end
   end

   gasp_place #(
      .COORD_BITS (COORD_BITS),
      .PAGE_BITS  (PAGE_BITS)
   ) u_place (
      .padding          (padding_ff),
      .max_dim_log2     (max_dim_log2_ff),
      .glyph_width      (req_width_ff),
      .glyph_height     (req_height_ff),
      .cursor_x         (cursor_x_ff),
      .cursor_y         (cursor_y_ff),
      .row_height       (row_height_ff),
      .width_log2       (width_log2_ff),
      .height_log2      (height_log2_ff),
      .page             (page_ff),
      .cursor_x_next    (cursor_x_in),
      .cursor_y_next    (cursor_y_in),
      .row_height_next  (row_height_in),
      .width_log2_next  (width_log2_in),
      .height_log2_next (height_log2_in),
      .page_next        (page_in),
      .status           (status_c),
      .pos_x            (pos_x_c),
      .pos_y            (pos_y_c)
   );

   assign pos_x_wide = W'(pos_x_c);
   assign pos_y_wide = W'(pos_y_c);
   assign page_wide  = 16'(page_in);

   // packer state and result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff    <= COORD_BITS'(gasp_pkg::PADDING_RESET);
         cursor_y_ff    <= COORD_BITS'(gasp_pkg::PADDING_RESET);
         row_height_ff  <= COORD_BITS'(gasp_pkg::PADDING_RESET);
         width_log2_ff  <= gasp_pkg::MIN_LOG2;
         height_log2_ff <= gasp_pkg::MIN_LOG2;
         page_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            cursor_x_ff    <= cursor_x_in;
            cursor_y_ff    <= cursor_y_in;
            row_height_ff  <= row_height_in;
            width_log2_ff  <= width_log2_in;
            height_log2_ff <= height_log2_in;
            page_ff        <= page_in;
         end
      end
      if (out_free && req_valid_ff) begin
         rsp_code_ff         <= req_code_ff;
         rsp_status_ff       <= status_c;
         rsp_pos_x_ff        <= pos_x_wide[gasp_pkg::POS_BITS-1:0];
         rsp_pos_y_ff        <= pos_y_wide[gasp_pkg::POS_BITS-1:0];
         rsp_page_ff         <= page_wide[gasp_pkg::PAGE_OUT_BITS-1:0];
         rsp_atlas_width_ff  <= gasp_pkg::ATLAS_DIM_BITS'(1) << width_log2_in;
         rsp_atlas_height_ff <= gasp_pkg::ATLAS_DIM_BITS'(1) << height_log2_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_out     = rsp_code_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_page_out     = rsp_page_ff;
   assign rsp_atlas_width  = rsp_atlas_width_ff;
   assign rsp_atlas_height = rsp_atlas_height_ff;

endmodule

>>> hw/rtl/gasp_place.sv
// Placement logic: fit checks, new row, page or regrow, cursor update
module gasp_place #(
   parameter int COORD_BITS = 12,
   parameter int PAGE_BITS  = 8
) (
   input  logic [3:0]                          padding,
   input  logic [3:0]                          max_dim_log2,
   input  logic [gasp_pkg::GLYPH_DIM_BITS-1:0] glyph_width,
   input  logic [gasp_pkg::GLYPH_DIM_BITS-1:0] glyph_height,
   input  logic [COORD_BITS-1:0]               cursor_x,
   input  logic [COORD_BITS-1:0]               cursor_y,
   input  logic [COORD_BITS-1:0]               row_height,
   input  logic [3:0]                          width_log2,
   input  logic [3:0]                          height_log2,
   input  logic [PAGE_BITS-1:0]                page,
   output logic [COORD_BITS-1:0]               cursor_x_next,
   output logic [COORD_BITS-1:0]               cursor_y_next,
   output logic [COORD_BITS-1:0]               row_height_next,
   output logic [3:0]                          width_log2_next,
   output logic [3:0]                          height_log2_next,
   output logic [PAGE_BITS-1:0]                page_next,
   output gasp_pkg::status_type                status,
   output logic [COORD_BITS-1:0]               pos_x,
   output logic [COORD_BITS-1:0]               pos_y
);

   localparam int W = gasp_pkg::WIDE_BITS;
   localparam logic [W-1:0] CMAX = W'((1 << COORD_BITS) - 1);
   localparam logic [3:0] TOP_LOG2 =
      (COORD_BITS < 12) ? 4'(COORD_BITS) : gasp_pkg::MAX_TOP_LOG2;

   function automatic logic [COORD_BITS-1:0] sat_coord(input logic [W-1:0] v);
      logic [COORD_BITS-1:0] r;
      r = (v > CMAX) ? CMAX[COORD_BITS-1:0] : v[COORD_BITS-1:0];
      return r;
   endfunction

   logic [W-1:0] p_w, w_w, h_w, aw_w, ah_w;
   logic [W-1:0] cx_w, cy_w, rh_w;
   logic [COORD_BITS-1:0] pad_c;
   logic [COORD_BITS-1:0] cx_a, cy_a, rh_a, cx_b, cy_b, rh_b, rh_glyph;
   logic [3:0] limit;
   logic fits, new_row, no_room, can_grow, regrown, new_page, empty;

   always_comb begin
      p_w   = W'(padding);
      w_w   = W'(glyph_width);
      h_w   = W'(glyph_height);
      aw_w  = W'(1) << width_log2;
      ah_w  = W'(1) << height_log2;
      cx_w  = W'(cursor_x);
      cy_w  = W'(cursor_y);
      rh_w  = W'(row_height);
      pad_c = COORD_BITS'(padding);

      fits    = (w_w + (p_w << 1) < aw_w) && (h_w + (p_w << 1) < ah_w);
      new_row = fits && (cx_w + w_w + p_w > aw_w);
      cx_a    = new_row ? pad_c : cursor_x;
      cy_a    = new_row ? sat_coord(cy_w + rh_w) : cursor_y;
      rh_a    = new_row ? pad_c : row_height;

      if (max_dim_log2 < gasp_pkg::MIN_LOG2) begin
         limit = gasp_pkg::MIN_LOG2;
      end else if (max_dim_log2 > TOP_LOG2) begin
         limit = TOP_LOG2;
      end else begin
         limit = max_dim_log2;
      end

      no_room  = fits && (W'(cy_a) + h_w + p_w > ah_w);
      can_grow = ({1'b0, width_log2} + 5'd1 <= {1'b0, limit}) ||
                 ({1'b0, height_log2} + 5'd1 <= {1'b0, limit});
      regrown  = no_room && can_grow;
      new_page = no_room && !can_grow;

      width_log2_next  = (regrown && (width_log2 == height_log2)) ?
                         width_log2 + 4'd1 : width_log2;
      height_log2_next = (regrown && (width_log2 != height_log2)) ?
                         height_log2 + 4'd1 : height_log2;
      page_next        = new_page ? page + PAGE_BITS'(1) : page;

      cx_b = no_room ? pad_c : cx_a;
      cy_b = no_room ? pad_c : cy_a;
      rh_b = no_room ? pad_c : rh_a;

      empty    = (glyph_width == '0) || (glyph_height == '0);
      rh_glyph = sat_coord(h_w + p_w);

      cursor_x_next   = cx_b;
      cursor_y_next   = cy_b;
      row_height_next = rh_b;
      pos_x           = '0;
      pos_y           = '0;

      priority if (regrown) begin
         status = gasp_pkg::STATUS_REGROW;
      end else if (empty) begin
         status = gasp_pkg::STATUS_EMPTY;
      end else begin
         status          = fits ? gasp_pkg::STATUS_PLACED : gasp_pkg::STATUS_OVERSIZE;
         pos_x           = cx_b;
         pos_y           = cy_b;
         cursor_x_next   = sat_coord(W'(cx_b) + w_w + p_w);
         row_height_next = (rh_glyph > rh_b) ? rh_glyph : rh_b;
      end
   end

endmodule

>>> hw/rtl/gasp_checker.sv
// Port checker of the glyph atlas shelf packer and its bind to the top level
`include "assert_macros.svh"

module gasp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [gasp_pkg::GLYPH_CODE_BITS-1:0]  req_glyph_code,
   input logic [gasp_pkg::GLYPH_DIM_BITS-1:0]   req_glyph_width,
   input logic [gasp_pkg::GLYPH_DIM_BITS-1:0]   req_glyph_height,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [gasp_pkg::GLYPH_CODE_BITS-1:0]  rsp_code_out,
   input logic [1:0]                            rsp_status,
   input logic [gasp_pkg::POS_BITS-1:0]         rsp_pos_x,
   input logic [gasp_pkg::POS_BITS-1:0]         rsp_pos_y,
   input logic [gasp_pkg::PAGE_OUT_BITS-1:0]    rsp_page_out,
   input logic [gasp_pkg::ATLAS_DIM_BITS-1:0]   rsp_atlas_width,
   input logic [gasp_pkg::ATLAS_DIM_BITS-1:0]   rsp_atlas_height,
   input logic                                  csr_write,
   input logic [gasp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input logic [gasp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   `GASP_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_code_out) && $stable(rsp_status) && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_page_out)), "stalled result beat changed")

   `GASP_ASSERT_IMPLY(a_atlas_pow2, rsp_valid, ($onehot(rsp_atlas_width) && $onehot(rsp_atlas_height) && (rsp_atlas_height >= 13'd128)), "atlas size not a power of two of at least 128")

   `GASP_ASSERT_IMPLY(a_atlas_shape, rsp_valid, ((rsp_atlas_height <= rsp_atlas_width) && ({1'b0, rsp_atlas_width} <= {rsp_atlas_height, 1'b0})), "atlas neither square nor two by one")

   `GASP_ASSERT_IMPLY(a_unplaced_origin, rsp_valid && ((rsp_status == gasp_pkg::STATUS_REGROW) || (rsp_status == gasp_pkg::STATUS_EMPTY)), ((rsp_pos_x == '0) && (rsp_pos_y == '0)), "unplaced beat carries a position")

endmodule

bind glyph_atlas_shelf_packer_unit gasp_checker u_gasp_checker (.*);
